[rtl/core/light_sensor_average_lux_unit_macros.svh]
// Assertion macros shared by the light sensor average lux unit.
`ifndef LIGHT_SENSOR_AVERAGE_LUX_UNIT_MACROS_SVH
`define LIGHT_SENSOR_AVERAGE_LUX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LSAL_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lsal: same-cycle check failed");
`define LSAL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lsal: next-cycle check failed");
`else
`define LSAL_ASSERT_IMPLY(label, clk, rst, pre, post)
`define LSAL_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/core/lsal_pkg.sv]
// Types, constants and the microcode table of the average lux unit.
`default_nettype none
package lsal_pkg;

   localparam int COUNT_W = 16;
   localparam int SUM_W   = 24;
   localparam int LUX_W   = 29;
   localparam int DEN_W   = 26;
   localparam int N_W     = 19;
   localparam int NUM_W0  = 32;
   localparam int TG_W    = 15;
   localparam int STEP_W  = 4;

   localparam logic [LUX_W-1:0] LUX_MAX   = '1;
   localparam logic [12:0]      LUX_SCALE = 13'd6625;
   localparam logic [10:0]      LUX_DIV   = 11'd1706;

   localparam logic [1:0] CSR_INTEGRATION = 2'd0;
   localparam logic [1:0] CSR_GAIN        = 2'd1;
   localparam logic [1:0] CSR_SAMPLES     = 2'd2;

   localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ACC      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LOAD_A0  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_WAIT_A0  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_LOAD_A1  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_WAIT_A1  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_STORE_A1 = 4'd6;
   localparam logic [STEP_W-1:0] STEP_FORM_N   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SCALE    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_LOAD_LUX = 4'd9;
   localparam logic [STEP_W-1:0] STEP_WAIT_LUX = 4'd10;
   localparam logic [STEP_W-1:0] STEP_LUX_DONE = 4'd11;
   localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd12;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_ACC,
      OP_LOAD_A0,
      OP_WAIT,
      OP_LOAD_A1,
      OP_STORE_A1,
      OP_FORM_N,
      OP_SCALE,
      OP_LOAD_LUX,
      OP_LUX_DONE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_NOT_RUN_END,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] jump;
      logic [STEP_W-1:0] next;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic run_end;
      logic div_busy;
      logic out_busy;
   } status_type;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type word;
      unique case (step)
         STEP_IDLE:     word = '{OP_IDLE,     COND_NO_REQ,      STEP_IDLE,     STEP_ACC};
         STEP_ACC:      word = '{OP_ACC,      COND_NOT_RUN_END, STEP_EMIT,     STEP_LOAD_A0};
         STEP_LOAD_A0:  word = '{OP_LOAD_A0,  COND_NEVER,       STEP_IDLE,     STEP_WAIT_A0};
         STEP_WAIT_A0:  word = '{OP_WAIT,     COND_DIV_BUSY,    STEP_WAIT_A0,  STEP_LOAD_A1};
         STEP_LOAD_A1:  word = '{OP_LOAD_A1,  COND_NEVER,       STEP_IDLE,     STEP_WAIT_A1};
         STEP_WAIT_A1:  word = '{OP_WAIT,     COND_DIV_BUSY,    STEP_WAIT_A1,  STEP_STORE_A1};
         STEP_STORE_A1: word = '{OP_STORE_A1, COND_NEVER,       STEP_IDLE,     STEP_FORM_N};
         STEP_FORM_N:   word = '{OP_FORM_N,   COND_NEVER,       STEP_IDLE,     STEP_SCALE};
         STEP_SCALE:    word = '{OP_SCALE,    COND_NEVER,       STEP_IDLE,     STEP_LOAD_LUX};
         STEP_LOAD_LUX: word = '{OP_LOAD_LUX, COND_NEVER,       STEP_IDLE,     STEP_WAIT_LUX};
         STEP_WAIT_LUX: word = '{OP_WAIT,     COND_DIV_BUSY,    STEP_WAIT_LUX, STEP_LUX_DONE};
         STEP_LUX_DONE: word = '{OP_LUX_DONE, COND_NEVER,       STEP_IDLE,     STEP_EMIT};
         STEP_EMIT:     word = '{OP_EMIT,     COND_OUT_BUSY,    STEP_EMIT,     STEP_IDLE};
         default:       word = '{OP_IDLE,     COND_NEVER,       STEP_IDLE,     STEP_IDLE};
      endcase
      return word;
   endfunction

   function automatic logic [6:0] gain_mult(input logic [1:0] code);
      logic [6:0] g;
      unique case (code)
         2'd0:    g = 7'd1;
         2'd1:    g = 7'd8;
         2'd2:    g = 7'd16;
         default: g = 7'd120;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

[rtl/core/lsal_divider.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none
module lsal_divider #(
   parameter int DVD_W = 40,
   parameter int DVS_W = 26,
   parameter int CNT_W = $clog2(DVD_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire logic [DVD_W-1:0] load_dividend,
   input  wire logic [DVS_W-1:0] load_divisor,
   input  wire logic [CNT_W-1:0] load_count,
   output logic                  busy,
   output logic [DVD_W-1:0]      quotient
);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      ge     = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (load) begin
         dvd_in = load_dividend;
         dvs_in = load_divisor;
         rem_in = '0;
         cnt_in = load_count;
      end else if (busy) begin
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = dvd_ff;

endmodule
`default_nettype wire

[rtl/core/lsal_sequencer.sv]
// Step counter and microcode table that steer the lux datapath.
`default_nettype none
module lsal_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lsal_pkg::status_type  status,
   output lsal_pkg::ctrl_word_type    ctrl
);

   logic [lsal_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        take_jump;

   assign ctrl = lsal_pkg::ucode_rom(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         lsal_pkg::COND_NO_REQ:      take_jump = !status.req_valid;
         lsal_pkg::COND_NOT_RUN_END: take_jump = !status.run_end;
         lsal_pkg::COND_DIV_BUSY:    take_jump = status.div_busy;
         lsal_pkg::COND_OUT_BUSY:    take_jump = status.out_busy;
         default:                    take_jump = 1'b0;
      endcase
      step_in = take_jump ? ctrl.jump : ctrl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lsal_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/light_sensor_average_lux_unit.sv]
// Top level of the two-channel averaging lux unit.
// One word is taken at a time. A reading that does not end an averaging run goes from the
// accumulate step straight to the emit step, and the next reading is taken back in the idle
// step. A reading that ends a run passes through two 24-step averaging divisions and one
// (32 + LUX_FRACTION_BITS)-step lux division on a single shared bit-serial divider before
// its emit step. The result waits in an output register, and the next reading is taken as
// soon as the microcode returns to its idle step.
`default_nettype none
`include "light_sensor_average_lux_unit_macros.svh"
module light_sensor_average_lux_unit #(
   parameter int LUX_FRACTION_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_broadband_count,
   input  wire logic [15:0] req_infrared_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_saturated,
   output logic             rsp_lux_valid,
   output logic [28:0]      rsp_lux_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int NUM_W = lsal_pkg::NUM_W0 + LUX_FRACTION_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   lsal_pkg::ctrl_word_type ctrl;
   lsal_pkg::status_type    status;

   logic [7:0]  atime_ff, atime_in;
   logic [1:0]  gain_ff, gain_in;
   logic [7:0]  samples_ff, samples_in;

   logic [lsal_pkg::COUNT_W-1:0] bb_ff, bb_in, ir_ff, ir_in;
   logic [lsal_pkg::SUM_W-1:0]   sum0_ff, sum0_in, sum1_ff, sum1_in;
   logic [7:0]                   readings_ff, readings_in;
   logic                         sat_ff, sat_in;
   logic                         lvalid_ff, lvalid_in;
   logic [lsal_pkg::LUX_W-1:0]   lux_ff, lux_in;
   logic [lsal_pkg::COUNT_W-1:0] a0_ff, a0_in, a1_ff, a1_in;
   logic [lsal_pkg::N_W-1:0]     n_ff, n_in;
   logic [lsal_pkg::TG_W-1:0]    tg_ff, tg_in;
   logic [lsal_pkg::NUM_W0-1:0]  num_ff, num_in;
   logic [lsal_pkg::DEN_W-1:0]   den_ff, den_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_sat_ff;
   logic                         rsp_lvalid_ff;
   logic [lsal_pkg::LUX_W-1:0]   rsp_lux_ff;

   logic [8:0]                   t_val;
   logic [15:0]                  full_scale;
   logic [15:0]                  sat_limit;
   logic [7:0]                   need;
   logic [8:0]                   taken;
   logic                         run_end;
   logic [20:0]                  a0w, a1w;
   logic signed [20:0]           f1, f2, n_max;
   logic                         out_busy;
   logic                         emit_go;

   logic                         div_load;
   logic [NUM_W-1:0]             div_dividend;
   logic [lsal_pkg::DEN_W-1:0]   div_divisor;
   logic [CNT_W-1:0]             div_count;
   logic                         div_busy;
   logic [NUM_W-1:0]             div_quotient;

   lsal_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   lsal_divider #(
      .DVD_W (NUM_W),
      .DVS_W (lsal_pkg::DEN_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock         (clock),
      .reset         (reset),
      .load          (div_load),
      .load_dividend (div_dividend),
      .load_divisor  (div_divisor),
      .load_count    (div_count),
      .busy          (div_busy),
      .quotient      (div_quotient)
   );

   assign req_stall = ctrl.op != lsal_pkg::OP_IDLE;
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign emit_go   = (ctrl.op == lsal_pkg::OP_EMIT) && !out_busy;

   assign status = '{req_valid: req_valid, run_end: run_end,
                     div_busy: div_busy, out_busy: out_busy};

   always_comb begin
      t_val      = 9'd256 - {1'b0, atime_ff};
      full_scale = (t_val[8:6] != 3'd0) ? 16'hFFFF : {t_val[5:0], 10'd0};
      sat_limit  = full_scale - 16'd2;
      need       = (samples_ff == 8'd0) ? 8'd1 : samples_ff;
      taken      = {1'b0, readings_ff} + 9'd1;
      run_end    = taken >= {1'b0, need};
      a0w        = {5'd0, a0_ff};
      a1w        = {5'd0, a1_ff};
      f1         = (a0w << 2) + a0w - ((a1w << 3) + (a1w << 1));
      f2         = (a0w << 1) + a0w - ((a1w << 2) + a1w);
      n_max      = (f2 > f1) ? f2 : f1;
   end

   always_comb begin
      div_load     = 1'b0;
      div_dividend = NUM_W'(sum0_ff) << (NUM_W - lsal_pkg::SUM_W);
      div_divisor  = lsal_pkg::DEN_W'(readings_ff);
      div_count    = CNT_W'(lsal_pkg::SUM_W);
      unique case (ctrl.op)
         lsal_pkg::OP_LOAD_A0: begin
            div_load = 1'b1;
         end
         lsal_pkg::OP_LOAD_A1: begin
            div_load     = 1'b1;
            div_dividend = NUM_W'(sum1_ff) << (NUM_W - lsal_pkg::SUM_W);
         end
         lsal_pkg::OP_LOAD_LUX: begin
            div_load     = 1'b1;
            div_dividend = NUM_W'(num_ff) << LUX_FRACTION_BITS;
            div_divisor  = den_ff;
            div_count    = CNT_W'(NUM_W);
         end
         default: begin
            div_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      atime_in   = atime_ff;
      gain_in    = gain_ff;
      samples_in = samples_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lsal_pkg::CSR_INTEGRATION: atime_in   = csr_wdata;
            lsal_pkg::CSR_GAIN:        gain_in    = csr_wdata[1:0];
            lsal_pkg::CSR_SAMPLES:     samples_in = csr_wdata;
            default:                   atime_in   = atime_ff;
         endcase
      end
   end

   always_comb begin
      bb_in       = bb_ff;
      ir_in       = ir_ff;
      sum0_in     = sum0_ff;
      sum1_in     = sum1_ff;
      readings_in = readings_ff;
      sat_in      = sat_ff;
      lvalid_in   = lvalid_ff;
      lux_in      = lux_ff;
      a0_in       = a0_ff;
      a1_in       = a1_ff;
      n_in        = n_ff;
      tg_in       = tg_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      unique case (ctrl.op)
         lsal_pkg::OP_IDLE: begin
            if (req_valid) begin
               bb_in = req_broadband_count;
               ir_in = req_infrared_count;
            end
         end
         lsal_pkg::OP_ACC: begin
            sat_in      = (bb_ff >= sat_limit) || (ir_ff >= sat_limit);
            sum0_in     = sum0_ff + lsal_pkg::SUM_W'(bb_ff);
            sum1_in     = sum1_ff + lsal_pkg::SUM_W'(ir_ff);
            readings_in = taken[7:0];
            lvalid_in   = run_end;
            lux_in      = '0;
         end
         lsal_pkg::OP_LOAD_A1: begin
            a0_in = div_quotient[lsal_pkg::COUNT_W-1:0];
         end
         lsal_pkg::OP_STORE_A1: begin
            a1_in = div_quotient[lsal_pkg::COUNT_W-1:0];
         end
         lsal_pkg::OP_FORM_N: begin
            n_in  = (n_max > 21'sd0) ? n_max[lsal_pkg::N_W-1:0] : '0;
            tg_in = lsal_pkg::TG_W'(t_val) * lsal_pkg::TG_W'(lsal_pkg::gain_mult(gain_ff));
         end
         lsal_pkg::OP_SCALE: begin
            num_in = lsal_pkg::NUM_W0'(n_ff) * lsal_pkg::NUM_W0'(lsal_pkg::LUX_SCALE);
            den_in = lsal_pkg::DEN_W'(tg_ff) * lsal_pkg::DEN_W'(lsal_pkg::LUX_DIV);
         end
         lsal_pkg::OP_LUX_DONE: begin
            lux_in      = (div_quotient > NUM_W'(lsal_pkg::LUX_MAX)) ?
                          lsal_pkg::LUX_MAX : div_quotient[lsal_pkg::LUX_W-1:0];
            sum0_in     = '0;
            sum1_in     = '0;
            readings_in = '0;
         end
         default: begin
            sat_in = sat_ff;
         end
      endcase
   end

   assign rsp_valid_in = emit_go || out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         atime_ff     <= 8'd255;
         gain_ff      <= 2'd0;
         samples_ff   <= 8'd1;
         sum0_ff      <= '0;
         sum1_ff      <= '0;
         readings_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         atime_ff     <= atime_in;
         gain_ff      <= gain_in;
         samples_ff   <= samples_in;
         sum0_ff      <= sum0_in;
         sum1_ff      <= sum1_in;
         readings_ff  <= readings_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bb_ff     <= bb_in;
      ir_ff     <= ir_in;
      sat_ff    <= sat_in;
      lvalid_ff <= lvalid_in;
      lux_ff    <= lux_in;
      a0_ff     <= a0_in;
      a1_ff     <= a1_in;
      n_ff      <= n_in;
      tg_ff     <= tg_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      if (emit_go) begin
         rsp_sat_ff    <= sat_ff;
         rsp_lvalid_ff <= lvalid_ff;
         rsp_lux_ff    <= lux_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_lux_valid = rsp_lvalid_ff;
   assign rsp_lux_value = rsp_lux_ff;

   `LSAL_ASSERT_NEXT(a_accept_starts_acc, clock, reset, req_valid && !req_stall, ctrl.op == lsal_pkg::OP_ACC)
   `LSAL_ASSERT_IMPLY(a_div_only_in_wait, clock, reset, div_busy, ctrl.op == lsal_pkg::OP_WAIT)
   `LSAL_ASSERT_IMPLY(a_no_lux_without_run, clock, reset, rsp_valid && !rsp_lux_valid, rsp_lux_value == '0)
   `LSAL_ASSERT_NEXT(a_emit_returns_idle, clock, reset, emit_go, rsp_valid_ff && (ctrl.op == lsal_pkg::OP_IDLE))

endmodule
`default_nettype wire
